/* rtl/dacs_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dacs_pkg
// Shared types, constants and helpers for the accumulator machine step block.
// ----------------------------------------------------------------------------
package dacs_pkg;

    localparam int MEMORY_WORDS = 4096;
    localparam int MEM_AW       = $clog2(MEMORY_WORDS);

    localparam int IN_W  = 56;
    localparam int OUT_W = 120;

    localparam logic [5:0] TAPE_STOP = 6'd32;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_STEP  = 2'd1,
        CMD_RESET = 2'd2,
        CMD_READ  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_RUNNING  = 2'd0,
        ST_STOPPED  = 2'd1,
        ST_OVERFLOW = 2'd2,
        ST_WAITING  = 2'd3
    } t_run;

    typedef enum logic [1:0] {
        TS_PRESENT = 2'd0,
        TS_NOT_RDY = 2'd1,
        TS_END     = 2'd2,
        TS_BAD     = 2'd3
    } t_tape;

    typedef enum logic [3:0] {
        OP_STOP   = 4'h0,
        OP_LOAD   = 4'h1,
        OP_STADR  = 4'h2,
        OP_RETAD  = 4'h3,
        OP_TAPE   = 4'h4,
        OP_DIV    = 4'h5,
        OP_MULLO  = 4'h6,
        OP_MULHI  = 4'h7,
        OP_OUTCHR = 4'h8,
        OP_EXTR   = 4'h9,
        OP_JUMP   = 4'hA,
        OP_TEST   = 4'hB,
        OP_STORE  = 4'hC,
        OP_STCLR  = 4'hD,
        OP_ADD    = 4'hE,
        OP_SUB    = 4'hF
    } t_op;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DISPATCH,
        S_READ,
        S_FETCH,
        S_EXEC,
        S_ITER,
        S_ROUND,
        S_FINISH,
        S_RESULT
    } t_state;

    typedef enum logic [1:0] {
        RS_ADDR,
        RS_PC,
        RS_OPND
    } t_rsel;

    typedef struct packed {
        logic  in_ready;
        logic  clear_wr;
        logic  wr_in;
        logic  regs_rst;
        logic  step_begin;
        logic  tape_now;
        logic  latch_rd;
        logic  fetch;
        logic  exec;
        logic  iter_step;
        logic  round;
        logic  finish;
        logic  load_out;
        t_rsel rsel;
    } t_ctrl_cmd;

    typedef struct packed {
        t_cmd cmd;
        logic halted;
        logic tape_active;
        logic long_op;
        logic iter_last;
        logic clear_last;
        logic out_free;
    } t_dp_stat;

    // magnitude of the 31-bit value held in bits 31..1
    function automatic logic [30:0] word_mag(input logic [31:0] w);
        logic [30:0] v;
        v = w[31:1];
        word_mag = w[31] ? (~v + 31'd1) : v;
    endfunction

endpackage

`default_nettype wire

/* rtl/dacs_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dacs_ctrl
// Sequencer: store clearing, command dispatch, fetch/execute and iteration.
// ----------------------------------------------------------------------------
module dacs_ctrl (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    input  dacs_pkg::t_dp_stat   i_stat,
    output dacs_pkg::t_ctrl_cmd  o_cmd
);

    dacs_pkg::t_state r_state;
    dacs_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dacs_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.rsel = dacs_pkg::RS_ADDR;
        unique case (r_state)
            dacs_pkg::S_CLEAR: begin
                o_cmd.clear_wr = 1'b1;
                if (i_stat.clear_last) begin
                    n_state = dacs_pkg::S_IDLE;
                end
            end
            dacs_pkg::S_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_in_valid) begin
                    n_state = dacs_pkg::S_DISPATCH;
                end
            end
            dacs_pkg::S_DISPATCH: begin
                unique case (i_stat.cmd)
                    dacs_pkg::CMD_WRITE: begin
                        o_cmd.wr_in = 1'b1;
                        n_state     = dacs_pkg::S_RESULT;
                    end
                    dacs_pkg::CMD_RESET: begin
                        o_cmd.regs_rst = 1'b1;
                        n_state        = dacs_pkg::S_RESULT;
                    end
                    dacs_pkg::CMD_READ: begin
                        o_cmd.rsel = dacs_pkg::RS_ADDR;
                        n_state    = dacs_pkg::S_READ;
                    end
                    dacs_pkg::CMD_STEP: begin
                        if (i_stat.halted) begin
                            n_state = dacs_pkg::S_RESULT;
                        end else if (i_stat.tape_active) begin
                            o_cmd.step_begin = 1'b1;
                            o_cmd.tape_now   = 1'b1;
                            n_state          = dacs_pkg::S_RESULT;
                        end else begin
                            o_cmd.step_begin = 1'b1;
                            o_cmd.rsel       = dacs_pkg::RS_PC;
                            n_state          = dacs_pkg::S_FETCH;
                        end
                    end
                    default: n_state = dacs_pkg::S_RESULT;
                endcase
            end
            dacs_pkg::S_READ: begin
                o_cmd.latch_rd = 1'b1;
                n_state        = dacs_pkg::S_RESULT;
            end
            dacs_pkg::S_FETCH: begin
                o_cmd.fetch = 1'b1;
                o_cmd.rsel  = dacs_pkg::RS_OPND;
                n_state     = dacs_pkg::S_EXEC;
            end
            dacs_pkg::S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = i_stat.long_op ? dacs_pkg::S_ITER : dacs_pkg::S_RESULT;
            end
            dacs_pkg::S_ITER: begin
                o_cmd.iter_step = 1'b1;
                if (i_stat.iter_last) begin
                    n_state = dacs_pkg::S_ROUND;
                end
            end
            dacs_pkg::S_ROUND: begin
                o_cmd.round = 1'b1;
                n_state     = dacs_pkg::S_FINISH;
            end
            dacs_pkg::S_FINISH: begin
                o_cmd.finish = 1'b1;
                n_state      = dacs_pkg::S_RESULT;
            end
            dacs_pkg::S_RESULT: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = dacs_pkg::S_IDLE;
                end
            end
            default: n_state = dacs_pkg::S_IDLE;
        endcase
    end

endmodule

`default_nettype wire

/* rtl/dacs_datapath.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dacs_datapath
// Word store, machine registers, shift-add / restoring divide unit and the
// output word register.
// ----------------------------------------------------------------------------
module dacs_datapath (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  dacs_pkg::t_ctrl_cmd          i_cmd,
    input  wire                          i_in_valid,
    input  wire [dacs_pkg::IN_W-1:0]     i_in_data,
    input  wire [1:0]                    i_in_user,
    input  wire                          i_out_ready,
    output dacs_pkg::t_dp_stat           o_stat,
    output logic                         o_out_valid,
    output logic [dacs_pkg::OUT_W-1:0]   o_out_data
);

    localparam int AW = dacs_pkg::MEM_AW;

    logic [31:0] mem [dacs_pkg::MEMORY_WORDS];
    logic [31:0] r_rdata;
    logic [AW-1:0] raddr;
    logic          mem_we;
    logic [AW-1:0] mem_wa;
    logic [31:0]   mem_wd;

    logic [AW-1:0] r_clr, n_clr;

    dacs_pkg::t_cmd r_cmd, n_cmd;
    logic [11:0] r_addr, n_addr;
    logic [31:0] r_data, n_data;
    logic [1:0]  r_tstat, n_tstat;
    logic [5:0]  r_tcode, n_tcode;

    logic [31:0] r_acc, n_acc;
    logic [11:0] r_pc, n_pc;
    logic [31:0] r_instr, n_instr;
    dacs_pkg::t_run r_status, n_status;
    logic        r_tape, n_tape;
    logic [3:0]  r_shift, n_shift;

    logic        r_pv, n_pv;
    logic [5:0]  r_pcode, n_pcode;
    logic        r_taken, n_taken;
    logic [31:0] r_rd, n_rd;

    logic [30:0] r_hi, n_hi;
    logic [30:0] r_lo, n_lo;
    logic [30:0] r_opd, n_opd;
    logic [4:0]  r_cnt, n_cnt;
    logic        r_neg, n_neg;
    logic [30:0] r_q, n_q;
    logic        r_qovf, n_qovf;

    logic                       r_ovalid, n_ovalid;
    logic [dacs_pkg::OUT_W-1:0] r_out, n_out;

    dacs_pkg::t_op op;
    logic [11:0] opnd_a;
    logic [30:0] ma, mb;
    logic        div_ok;
    logic        do_tape;
    logic [3:0]  sh_cur;
    logic [3:0]  sh_nxt;
    logic [31:0] sum;
    logic [31:0] addend;
    logic [31:0] dsh;
    logic [31:0] msum;
    logic [30:0] q_rnd;
    logic [30:0] val;

    assign op     = dacs_pkg::t_op'(r_instr[19:16]);
    assign opnd_a = r_instr[14:3];
    assign ma     = dacs_pkg::word_mag(r_acc);
    assign mb     = dacs_pkg::word_mag(r_rdata);
    assign div_ok = (mb != '0) && (ma < mb);

    always_comb begin
        unique case (i_cmd.rsel)
            dacs_pkg::RS_ADDR: raddr = r_addr[AW-1:0];
            dacs_pkg::RS_PC:   raddr = r_pc[AW-1:0];
            dacs_pkg::RS_OPND: raddr = r_rdata[AW+2:3];
            default:           raddr = r_addr[AW-1:0];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        r_rdata <= mem[raddr];
    end

    always_comb begin
        n_clr = r_clr;
        n_cmd = r_cmd; n_addr = r_addr; n_data = r_data;
        n_tstat = r_tstat; n_tcode = r_tcode;
        n_acc = r_acc; n_pc = r_pc; n_instr = r_instr;
        n_status = r_status; n_tape = r_tape; n_shift = r_shift;
        n_pv = r_pv; n_pcode = r_pcode; n_taken = r_taken; n_rd = r_rd;
        n_hi = r_hi; n_lo = r_lo; n_opd = r_opd; n_cnt = r_cnt;
        n_neg = r_neg; n_q = r_q; n_qovf = r_qovf;
        n_ovalid = r_ovalid; n_out = r_out;
        mem_we = 1'b0;
        mem_wa = r_addr[AW-1:0];
        mem_wd = '0;
        sh_cur = '0;
        sh_nxt = '0;
        sum    = '0;
        addend = '0;
        dsh    = '0;
        msum   = '0;
        q_rnd  = '0;
        val    = '0;
        do_tape = i_cmd.tape_now || (i_cmd.exec && op == dacs_pkg::OP_TAPE);

        if (i_cmd.clear_wr) begin
            mem_we = 1'b1;
            mem_wa = r_clr;
            mem_wd = '0;
            n_clr  = r_clr + 1'b1;
        end

        if (i_cmd.in_ready && i_in_valid) begin
            n_cmd   = dacs_pkg::t_cmd'(i_in_user);
            n_addr  = i_in_data[11:0];
            n_data  = i_in_data[43:12];
            n_tstat = i_in_data[45:44];
            n_tcode = i_in_data[51:46];
            n_pv    = 1'b0;
            n_pcode = '0;
            n_taken = 1'b0;
            n_rd    = '0;
        end

        if (i_cmd.wr_in) begin
            mem_we = 1'b1;
            mem_wa = r_addr[AW-1:0];
            mem_wd = {r_data[31:1], 1'b0};
        end

        if (i_cmd.regs_rst) begin
            n_acc = '0; n_pc = '0; n_instr = '0;
            n_status = dacs_pkg::ST_RUNNING; n_tape = 1'b0; n_shift = '0;
        end

        if (i_cmd.step_begin) begin
            n_status = dacs_pkg::ST_RUNNING;
        end

        if (i_cmd.latch_rd) begin
            n_rd = r_rdata;
        end

        if (i_cmd.fetch) begin
            n_instr = r_rdata;
            n_pc    = r_pc + 12'd1;
        end

        if (i_cmd.exec) begin
            unique case (op)
                dacs_pkg::OP_STOP:  n_status = dacs_pkg::ST_STOPPED;
                dacs_pkg::OP_LOAD:  n_acc = r_rdata;
                dacs_pkg::OP_STADR: begin
                    mem_we = 1'b1;
                    mem_wa = opnd_a[AW-1:0];
                    mem_wd = {r_rdata[31:15], r_acc[14:3], r_rdata[2:1], 1'b0};
                end
                dacs_pkg::OP_RETAD: begin
                    mem_we = 1'b1;
                    mem_wa = opnd_a[AW-1:0];
                    mem_wd = {r_rdata[31:15], r_pc + 12'd1, r_rdata[2:1], 1'b0};
                end
                dacs_pkg::OP_TAPE: begin
                    n_tape  = 1'b1;
                    n_shift = '0;
                end
                dacs_pkg::OP_DIV: begin
                    n_neg = r_acc[31] ^ r_rdata[31];
                    n_hi  = ma;
                    n_lo  = '0;
                    n_opd = mb;
                    n_cnt = 5'd29;
                    if (!div_ok) begin
                        n_status = dacs_pkg::ST_OVERFLOW;
                    end
                end
                dacs_pkg::OP_MULLO, dacs_pkg::OP_MULHI: begin
                    n_neg = r_acc[31] ^ r_rdata[31];
                    n_hi  = '0;
                    n_lo  = mb;
                    n_opd = ma;
                    n_cnt = 5'd30;
                end
                dacs_pkg::OP_OUTCHR: begin
                    n_pv    = 1'b1;
                    n_pcode = opnd_a[11:6];
                end
                dacs_pkg::OP_EXTR: n_acc = r_acc & r_rdata;
                dacs_pkg::OP_JUMP: n_pc = opnd_a;
                dacs_pkg::OP_TEST: begin
                    if (r_acc[31]) begin
                        n_pc = opnd_a;
                    end
                end
                dacs_pkg::OP_STORE, dacs_pkg::OP_STCLR: begin
                    mem_we = 1'b1;
                    mem_wa = opnd_a[AW-1:0];
                    mem_wd = {r_acc[31:1], 1'b0};
                    if (op == dacs_pkg::OP_STCLR) begin
                        n_acc = '0;
                    end
                end
                dacs_pkg::OP_ADD, dacs_pkg::OP_SUB: begin
                    addend = {r_rdata[31], r_rdata[31:1]};
                    if (op == dacs_pkg::OP_ADD) begin
                        sum = {r_acc[31], r_acc[31:1]} + addend;
                    end else begin
                        sum = {r_acc[31], r_acc[31:1]} - addend;
                    end
                    if (sum[31] != sum[30]) begin
                        n_status = dacs_pkg::ST_OVERFLOW;
                    end else begin
                        n_acc = {sum[30:0], 1'b0};
                    end
                end
                default: n_status = r_status;
            endcase
        end

        // one tape character per step
        if (do_tape) begin
            sh_cur = i_cmd.tape_now ? r_shift : 4'd0;
            sh_nxt = sh_cur + 4'd1;
            priority if (r_tstat == dacs_pkg::TS_END) begin
                n_tape   = 1'b0;
                n_status = dacs_pkg::ST_STOPPED;
            end else if (r_tstat != dacs_pkg::TS_PRESENT) begin
                n_status = dacs_pkg::ST_WAITING;
            end else begin
                n_taken = 1'b1;
                if (r_tcode == dacs_pkg::TAPE_STOP) begin
                    n_tape = 1'b0;
                end else begin
                    n_acc   = {r_acc[27:0], r_tcode[3:0]};
                    n_shift = sh_nxt;
                    if (sh_nxt[3]) begin
                        n_tape = 1'b0;
                    end
                end
            end
        end

        if (i_cmd.iter_step) begin
            n_cnt = r_cnt - 5'd1;
            if (op == dacs_pkg::OP_DIV) begin
                dsh = {r_hi, 1'b0};
                if (dsh >= {1'b0, r_opd}) begin
                    dsh  = dsh - {1'b0, r_opd};
                    n_lo = {r_lo[29:0], 1'b1};
                end else begin
                    n_lo = {r_lo[29:0], 1'b0};
                end
                n_hi = dsh[30:0];
            end else begin
                msum = {1'b0, r_hi} + (r_lo[0] ? {1'b0, r_opd} : 32'd0);
                n_hi = msum[31:1];
                n_lo = {msum[0], r_lo[30:1]};
            end
        end

        if (i_cmd.round) begin
            unique case (op)
                dacs_pkg::OP_DIV: begin
                    q_rnd  = {1'b0, r_lo[29:0]} +
                             (({r_hi, 1'b0} >= {1'b0, r_opd}) ? 31'd1 : 31'd0);
                    n_q    = q_rnd;
                    n_qovf = q_rnd[30];
                end
                dacs_pkg::OP_MULHI: begin
                    n_q    = {1'b0, r_hi[28:0], r_lo[30]};
                    n_qovf = 1'b0;
                end
                default: begin
                    n_q    = r_lo;
                    n_qovf = 1'b0;
                end
            endcase
        end

        if (i_cmd.finish) begin
            val = r_neg ? (~r_q + 31'd1) : r_q;
            priority if (op == dacs_pkg::OP_MULLO) begin
                n_acc = {r_q, 1'b0};
            end else if (r_qovf) begin
                n_status = dacs_pkg::ST_OVERFLOW;
            end else begin
                n_acc = {val, 1'b0};
            end
        end

        if (r_ovalid && i_out_ready) begin
            n_ovalid = 1'b0;
        end
        if (i_cmd.load_out) begin
            n_ovalid = 1'b1;
            n_out    = {2'b00, r_rd, r_taken, r_pcode, r_pv, r_instr, r_pc, r_acc,
                        r_status};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr    <= '0;
            r_acc    <= '0;
            r_pc     <= '0;
            r_instr  <= '0;
            r_status <= dacs_pkg::ST_RUNNING;
            r_tape   <= 1'b0;
            r_shift  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_clr    <= n_clr;
            r_acc    <= n_acc;
            r_pc     <= n_pc;
            r_instr  <= n_instr;
            r_status <= n_status;
            r_tape   <= n_tape;
            r_shift  <= n_shift;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd   <= n_cmd;
        r_addr  <= n_addr;
        r_data  <= n_data;
        r_tstat <= n_tstat;
        r_tcode <= n_tcode;
        r_pv    <= n_pv;
        r_pcode <= n_pcode;
        r_taken <= n_taken;
        r_rd    <= n_rd;
        r_hi    <= n_hi;
        r_lo    <= n_lo;
        r_opd   <= n_opd;
        r_cnt   <= n_cnt;
        r_neg   <= n_neg;
        r_q     <= n_q;
        r_qovf  <= n_qovf;
        r_out   <= n_out;
    end

    always_comb begin
        o_stat.cmd         = r_cmd;
        o_stat.halted      = (r_status == dacs_pkg::ST_STOPPED) ||
                             (r_status == dacs_pkg::ST_OVERFLOW);
        o_stat.tape_active = r_tape;
        o_stat.long_op     = (op == dacs_pkg::OP_MULLO) || (op == dacs_pkg::OP_MULHI) ||
                             ((op == dacs_pkg::OP_DIV) && div_ok);
        o_stat.iter_last   = (r_cnt == 5'd0);
        o_stat.clear_last  = (r_clr == AW'(dacs_pkg::MEMORY_WORDS - 1));
        o_stat.out_free    = !r_ovalid || i_out_ready;
    end

    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

/* rtl/drum_accumulator_cpu_step.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// drum_accumulator_cpu_step
// One-address accumulator machine: store access, register reset and single
// instruction steps, one result word per command word.
// ----------------------------------------------------------------------------
// multiply and divide use a serial unit: one quotient or product bit a cycle
// throughput: one command word at a time, the next accepted once its result
//   is registered
// reset: synchronous active low; clears registers, then sweeps all 4096 words
//   of the word store to zero, one word a cycle, before the first word is accepted
module drum_accumulator_cpu_step (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              s_axis_tvalid,
    output logic                             s_axis_tready,
    // address[11:0], data[43:12], tape_status[45:44], tape_code[51:46], zero pad
    input  wire [dacs_pkg::IN_W-1:0]         s_axis_tdata,
    // command[1:0]
    input  wire [1:0]                        s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  wire                              m_axis_tready,
    // status[1:0], accumulator[33:2], counter[45:34], instruction[77:46],
    // print_valid[78], print_code[84:79], tape_taken[85], read_data[117:86], pad
    output logic [dacs_pkg::OUT_W-1:0]       m_axis_tdata
);

    dacs_pkg::t_ctrl_cmd cmd;
    dacs_pkg::t_dp_stat  stat;

    dacs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    dacs_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in_valid  (s_axis_tvalid),
        .i_in_data   (s_axis_tdata),
        .i_in_user   (s_axis_tuser),
        .i_out_ready (m_axis_tready),
        .o_stat      (stat),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata)
    );

    assign s_axis_tready = cmd.in_ready;

    // one command word in flight
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("second word accepted while one is in flight");

    // a result is never loaded over one still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_out |-> (!m_axis_tvalid || m_axis_tready))
        else $error("result word overwritten");

    // the serial unit only runs while the input side is closed
    a_iter_closed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.iter_step |-> !s_axis_tready)
        else $error("input open during iteration");

endmodule

`default_nettype wire
